// ===== sv/rfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

    localparam logic [7:0]  PREFIX_BYTE   = 8'h0A;
    localparam logic [7:0]  FUNC_BYTE     = 8'h03;
    localparam logic [7:0]  END_BYTE      = 8'h0D;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_SHIFTMASK = 16'h7FFF;

    // field widths of the result bus
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 24;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_PREFIX = 3'd1,
        ST_BAD_ADDR   = 3'd2,
        ST_BAD_FUNC   = 3'd3,
        ST_BAD_END    = 3'd4,
        ST_BAD_CRC    = 3'd5
    } t_status;

    // one byte of reflected crc-16, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        logic        lsb;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            lsb = crc[0];
            crc = (crc >> 1) & CRC_SHIFTMASK;
            if (lsb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== sv/response_frame_checker_crc16.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Checks one response frame a byte per transaction: prefix 0x0A, address,
// function 0x03, length N, N payload bytes, crc low, crc high, end byte 0x0D.
// The address must equal the expected_address register, written through the
// cfg channel; the user must write it only while idle; the block does not
// enforce this. A crc-16 (reflected poly 0xA001, init 0xFFFF) covers address,
// function, length and payload. Payload bytes come out as they arrive (tuser
// 0); a status item (tuser 1, tlast 1) closes the frame: 0 ok, 1 bad prefix,
// 2 wrong address, 3 bad function, 4 bad end byte (wins over a crc error),
// 5 bad crc. A header error is reported at once and the rest of the frame
// is dropped until the next byte with tuser set, which always restarts the
// parser. Throughput is one byte per clock: each byte passes through the
// parser and crc update into the result register. s_axis_tready falls only
// while a result waits in that register and m_axis_tready is low.
module response_frame_checker_crc16 (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // configuration: expected_address
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [7:0]              i_cfg_data,
    // byte input
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [7:0]              s_axis_tdata,   // [7:0] rx_byte
    input  wire                     s_axis_tuser,   // [0] frame_start
    // result output
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [rfc_pkg::OUT_W-1:0] m_axis_tdata, // [7:0] payload_byte,
                                                    // [10:8] status,
                                                    // [18:11] payload_length,
                                                    // [23:19] zero
    output logic                    m_axis_tuser,   // [0] kind
    output logic                    m_axis_tlast    // last
);
    import rfc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ADDR    = 3'd1,
        PH_FUNC    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRCLO   = 3'd5,
        PH_CRCHI   = 3'd6,
        PH_END     = 3'd7
    } t_phase;

    // parser state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_length, n_length;
    logic [15:0] r_crc, n_crc;
    logic        r_mismatch, n_mismatch;
    logic [7:0]  r_exp_addr;

    // result register
    logic        r_out_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_payload, n_payload;
    t_status     r_status, n_status;
    logic [7:0]  r_out_len, n_out_len;
    logic        n_emit;

    logic        w_accept;
    logic [7:0]  w_byte;
    logic [15:0] w_crc_upd;
    logic [7:0]  w_count_inc;

    // result register frees up when empty or drained this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_byte        = s_axis_tdata;
    assign w_crc_upd     = crc16_byte(r_crc, w_byte);
    assign w_count_inc   = r_byte_count + 8'd1;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_byte_count = r_byte_count;
        n_length   = r_length;
        n_crc      = r_crc;
        n_mismatch = r_mismatch;
        n_emit     = 1'b0;
        n_kind     = 1'b1;
        n_payload  = 8'h00;
        n_status   = ST_OK;
        n_out_len  = 8'h00;
        if (s_axis_tuser) begin
            // restart on any flagged byte, dropping an unfinished frame
            n_byte_count = 8'h00;
            n_length     = 8'h00;
            n_crc        = CRC_INIT;
            n_mismatch   = 1'b0;
            if (w_byte != PREFIX_BYTE) begin
                n_emit   = 1'b1;
                n_status = ST_BAD_PREFIX;
                n_phase  = PH_IDLE;
            end else begin
                n_phase  = PH_ADDR;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    // stray bytes between frames are ignored
                end
                PH_ADDR: begin
                    if (w_byte != r_exp_addr) begin
                        n_emit   = 1'b1;
                        n_status = ST_BAD_ADDR;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_crc    = w_crc_upd;
                        n_phase  = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    if (w_byte != FUNC_BYTE) begin
                        n_emit   = 1'b1;
                        n_status = ST_BAD_FUNC;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_crc    = w_crc_upd;
                        n_phase  = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_length     = w_byte;
                    n_byte_count = 8'h00;
                    n_crc        = w_crc_upd;
                    // empty payload goes straight to the crc bytes
                    n_phase      = (w_byte == 8'h00) ? PH_CRCLO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_crc        = w_crc_upd;
                    n_byte_count = w_count_inc;
                    if (w_count_inc == r_length) begin
                        n_phase  = PH_CRCLO;
                    end
                    n_emit       = 1'b1;
                    n_kind       = 1'b0;
                    n_payload    = w_byte;
                end
                PH_CRCLO: begin
                    n_mismatch = (w_byte != r_crc[7:0]);
                    n_phase    = PH_CRCHI;
                end
                PH_CRCHI: begin
                    if (w_byte != r_crc[15:8]) begin
                        n_mismatch = 1'b1;
                    end
                    n_phase = PH_END;
                end
                PH_END: begin
                    // bad end byte outranks a crc error
                    n_emit    = 1'b1;
                    n_out_len = r_length;
                    n_phase   = PH_IDLE;
                    if (w_byte != END_BYTE) begin
                        n_status = ST_BAD_END;
                    end else if (r_mismatch) begin
                        n_status = ST_BAD_CRC;
                    end else begin
                        n_status = ST_OK;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_count <= 8'h00;
            r_length     <= 8'h00;
            r_crc        <= CRC_INIT;
            r_mismatch   <= 1'b0;
            r_exp_addr   <= 8'h00;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_exp_addr <= i_cfg_data;
            end
            if (w_accept) begin
                r_phase      <= n_phase;
                r_byte_count <= n_byte_count;
                r_length     <= n_length;
                r_crc        <= n_crc;
                r_mismatch   <= n_mismatch;
            end
            if (w_accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_kind    <= n_kind;
            r_payload <= n_payload;
            r_status  <= n_status;
            r_out_len <= n_out_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_kind;
    assign m_axis_tdata  = {{(OUT_W - 2*BYTE_W - STATUS_W){1'b0}},
                            r_out_len, r_status, r_payload};

    // a payload byte always yields a payload result in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !s_axis_tuser && r_phase == PH_PAYLOAD)
        |=> (r_out_valid && !r_kind))
        else $error("payload byte produced no payload result");

    // the payload counter never reaches the held length while in payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_byte_count < r_length))
        else $error("payload count overran length");

    // a flagged byte either opens a frame or reports a bad prefix
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser)
        |=> (r_phase == PH_ADDR || (r_out_valid && r_status == ST_BAD_PREFIX)))
        else $error("frame start not handled");

    // a stalled result is never overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> !$past(w_accept))
        else $error("input accepted over a stalled result");

endmodule

`default_nettype wire

// ===== sim/tb_response_frame_checker_crc16.sv =====
`timescale 1ns / 1ps

module tb_response_frame_checker_crc16;
    import rfc_pkg::*;

    // parser position inside a response frame
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ADDR    = 3'd1,
        PH_FUNC    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6,
        PH_END     = 3'd7
    } t_parse_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        t_status    status;
        logic [7:0] frame_len;
        logic       last;
    } t_frame_output;

    // how a generated frame gets damaged
    typedef enum int {
        FR_GOOD,
        FR_BAD_PREFIX,
        FR_BAD_ADDR,
        FR_BAD_FUNC,
        FR_BAD_CRC,
        FR_BAD_END,
        FR_CUT
    } t_frame_mode;

    // reflected crc-16, one data bit per step
    function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc_in,
                                                     input logic [7:0]  data);
        logic [15:0] crc;
        logic        feedback;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            feedback = crc[0] ^ data[i];
            crc      = {1'b0, crc[15:1]};
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    class frame_check_scoreboard;
        logic [7:0]    address;
        t_parse_phase  phase;
        logic [7:0]    payload_seen;
        logic [7:0]    held_len;
        logic [15:0]   running_crc;
        logic          crc_bad;
        t_frame_output awaited_outputs[$];
        int            mismatches;

        function new();
            address      = 8'h00;
            phase        = PH_IDLE;
            payload_seen = 8'h00;
            held_len     = 8'h00;
            running_crc  = CRC_INIT;
            crc_bad      = 1'b0;
            mismatches   = 0;
        endfunction

        function void push_status(input t_status st, input logic [7:0] len);
            t_frame_output r;
            r.kind      = 1'b1;
            r.data      = 8'h00;
            r.status    = st;
            r.frame_len = len;
            r.last      = 1'b1;
            awaited_outputs.push_back(r);
            phase = PH_IDLE;
        endfunction

        // advance the parser by one accepted byte
        function void take_byte(input logic [7:0] b, input logic start);
            t_frame_output r;
            if (start) begin
                payload_seen = 8'h00;
                held_len     = 8'h00;
                running_crc  = CRC_INIT;
                crc_bad      = 1'b0;
                if (b != PREFIX_BYTE) begin
                    push_status(ST_BAD_PREFIX, 8'h00);
                end else begin
                    phase = PH_ADDR;
                end
                return;
            end
            case (phase)
                PH_ADDR: begin
                    if (b != address) begin
                        push_status(ST_BAD_ADDR, 8'h00);
                    end else begin
                        running_crc = crc16_fold_byte(running_crc, b);
                        phase       = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    if (b != FUNC_BYTE) begin
                        push_status(ST_BAD_FUNC, 8'h00);
                    end else begin
                        running_crc = crc16_fold_byte(running_crc, b);
                        phase       = PH_LEN;
                    end
                end
                PH_LEN: begin
                    held_len     = b;
                    payload_seen = 8'h00;
                    running_crc  = crc16_fold_byte(running_crc, b);
                    phase        = (b == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    running_crc  = crc16_fold_byte(running_crc, b);
                    payload_seen = payload_seen + 8'd1;
                    if (payload_seen == held_len) begin
                        phase = PH_CRC_LO;
                    end
                    r.kind      = 1'b0;
                    r.data      = b;
                    r.status    = ST_OK;
                    r.frame_len = 8'h00;
                    r.last      = 1'b0;
                    awaited_outputs.push_back(r);
                end
                PH_CRC_LO: begin
                    crc_bad = (b != running_crc[7:0]);
                    phase   = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    if (b != running_crc[15:8]) begin
                        crc_bad = 1'b1;
                    end
                    phase = PH_END;
                end
                PH_END: begin
                    if (b != END_BYTE) begin
                        push_status(ST_BAD_END, held_len);
                    end else begin
                        push_status(crc_bad ? ST_BAD_CRC : ST_OK, held_len);
                    end
                end
                default: ;
            endcase
        endfunction

        // compare one output transaction with the oldest awaited one
        function void match_result(input logic kind, input logic [OUT_W-1:0] data,
                                   input logic last);
            t_frame_output e;
            if (awaited_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"unexpected output: kind %0d byte %02h status %0d",
                              " len %0d last %0d"},
                             kind, data[7:0], data[10:8], data[18:11], last);
                end
                return;
            end
            e = awaited_outputs.pop_front();
            if (kind !== e.kind || data[7:0] !== e.data || data[10:8] !== e.status ||
                data[18:11] !== e.frame_len || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"mismatch: expected kind %0d byte %02h status %0d",
                              " len %0d last %0d"},
                             e.kind, e.data, e.status, e.frame_len, e.last);
                    $display({"          got      kind %0d byte %02h status %0d",
                              " len %0d last %0d"},
                             kind, data[7:0], data[10:8], data[18:11], last);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int HOLD_CYCLES     = 400;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;   // [7:0] rx_byte
    logic             s_axis_tuser;   // [0] frame_start
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // [7:0] payload_byte, [10:8] status,
                                      // [18:11] payload_length, [23:19] zero
    logic             m_axis_tuser;   // [0] kind
    logic             m_axis_tlast;   // last

    frame_check_scoreboard sb;
    int   cycle_count = 0;
    int   items_sent  = 0;
    logic calm        = 1'b0;   // no idling on either side while set
    logic hold_request = 1'b0;  // asks the receiver for one long stall

    response_frame_checker_crc16 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit, a stuck handshake ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_response_frame_checker_crc16 failed");
            $finish;
        end
    end

    // receiver side: random stalls, one long hold when asked
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                m_axis_tready = calm || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // output monitor, sampled at the rising edge before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.match_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    // one byte transaction; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic start);
        // single idle cycle before about one byte in four
        if (!calm && $urandom_range(0, 99) < 23) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = start;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_byte(b, start);
        items_sent++;
        @(negedge i_clk);
    endtask

    // register write, only while nothing is in flight
    task automatic write_address(input logic [7:0] addr);
        i_cfg_valid = 1'b1;
        i_cfg_data  = addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.address = addr;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // sender pauses until every awaited output came out
    task automatic wait_for_drain();
        s_axis_tvalid = 1'b0;
        while (sb.awaited_outputs.size() != 0) @(posedge i_clk);
        // the extra wait covers a byte still in the parser
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // build one frame for the current address, damage it, send it
    task automatic send_frame(input int len, input t_frame_mode mode);
        logic [7:0]  fr[$];
        logic [15:0] c;
        logic [7:0]  b;
        int          n;
        fr = {};
        fr.push_back(PREFIX_BYTE);
        fr.push_back(sb.address);
        fr.push_back(FUNC_BYTE);
        fr.push_back(8'(len));
        c = CRC_INIT;
        for (int i = 1; i < 4; i++) begin
            c = crc16_fold_byte(c, fr[i]);
        end
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            fr.push_back(b);
            c = crc16_fold_byte(c, b);
        end
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        fr.push_back(END_BYTE);
        n = fr.size();
        case (mode)
            FR_BAD_PREFIX: fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
            FR_BAD_ADDR:   fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
            FR_BAD_FUNC:   fr[2] = fr[2] ^ 8'($urandom_range(1, 255));
            FR_BAD_CRC: begin
                n = len + 4 + $urandom_range(0, 1);
                fr[n] = fr[n] ^ 8'($urandom_range(1, 255));
                n = fr.size();
            end
            FR_BAD_END: begin
                fr[len + 6] = fr[len + 6] ^ 8'($urandom_range(1, 255));
                // bad end byte must win over a bad crc
                if ($urandom_range(0, 1)) begin
                    fr[len + 4] = fr[len + 4] ^ 8'($urandom_range(1, 255));
                end
            end
            FR_CUT:  n = $urandom_range(1, fr.size() - 1);
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            send_byte(fr[i], i == 0);
        end
    endtask

    initial begin
        logic [15:0] c;
        logic [7:0]  phase_addr[5];
        int          phase_end;
        int          r;
        int          len;
        t_frame_mode mode;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        sb = new();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part with address 5a
        write_address(8'h5A);
        c = crc16_fold_byte(crc16_fold_byte(crc16_fold_byte(CRC_INIT, 8'h5A),
                                            FUNC_BYTE), 8'h00);
        // bytes while idle are dropped
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // bad prefix
        send_byte(8'hFF, 1'b1);
        // wrong address, then a byte of the dropped rest
        send_byte(PREFIX_BYTE, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(FUNC_BYTE, 1'b0);
        // bad function code
        send_byte(PREFIX_BYTE, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h04, 1'b0);
        // good frame with zero length
        send_byte(PREFIX_BYTE, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(FUNC_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(c[7:0], 1'b0);
        send_byte(c[15:8], 1'b0);
        send_byte(END_BYTE, 1'b0);
        // restart mid-frame, then bad crc together with a bad end byte
        send_byte(PREFIX_BYTE, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(PREFIX_BYTE, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(FUNC_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(~c[7:0], 1'b0);
        send_byte(c[15:8], 1'b0);
        send_byte(8'h00, 1'b0);
        wait_for_drain();

        // random part, one address per phase, extremes included
        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = 8'($urandom);
        phase_addr[3] = PREFIX_BYTE;
        phase_addr[4] = 8'($urandom);
        items_sent = 0;
        for (int p = 0; p < 5; p++) begin
            write_address(phase_addr[p]);
            calm = (p == 2);
            // long receiver stall while bytes keep coming
            if (p == 3) begin
                hold_request = 1'b1;
            end
            phase_end = items_sent + ITEMS_PER_PHASE;
            // a frame with the longest payload, early in the run
            if (p == 1) begin
                send_frame(255, FR_GOOD);
            end
            while (items_sent < phase_end) begin
                r   = $urandom_range(0, 99);
                len = $urandom_range(0, 99);
                len = (len < 1) ? 255 : (len < 4) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 6);
                if (r < 8) begin
                    // noise, starts here and there
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom), $urandom_range(0, 9) == 0);
                    end
                end else begin
                    mode = (r < 58) ? FR_GOOD :
                           (r < 64) ? FR_BAD_PREFIX :
                           (r < 70) ? FR_BAD_ADDR :
                           (r < 76) ? FR_BAD_FUNC :
                           (r < 84) ? FR_BAD_CRC :
                           (r < 92) ? FR_BAD_END : FR_CUT;
                    send_frame(len, mode);
                end
            end
            wait_for_drain();
        end

        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited_outputs.size() == 0) begin
            $display("tb_response_frame_checker_crc16 passed");
        end else begin
            $display("tb_response_frame_checker_crc16 failed");
        end
        $finish;
    end

endmodule

// ===== response_frame_checker_crc16.f =====
sv/rfc_pkg.sv
sv/response_frame_checker_crc16.sv
sim/tb_response_frame_checker_crc16.sv
